/* hdl/csm_pkg.sv */
package csm_pkg;

  localparam int WORD_W   = 64;
  localparam int MODE_W   = 4;
  localparam int STATUS_W = 3;
  localparam int BUDGET_W = 16;

  localparam logic [BUDGET_W-1:0] BUDGET_RESET = 16'd4096;

  // decoded instruction codes
  typedef enum logic [MODE_W-1:0] {
    MODE_START = 4'd0,
    MODE_PUSH  = 4'd1,
    MODE_ADD   = 4'd2,
    MODE_SUB   = 4'd3,
    MODE_MUL   = 4'd4,
    MODE_AND   = 4'd5,
    MODE_OR    = 4'd6,
    MODE_XOR   = 4'd7,
    MODE_EQ    = 4'd8,
    MODE_DUP   = 4'd9,
    MODE_DROP  = 4'd10,
    MODE_SWAP  = 4'd11,
    MODE_POP   = 4'd12,
    MODE_HALT  = 4'd13
  } mode_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_OVERFLOW  = 3'd1,
    ST_UNDERFLOW = 3'd2,
    ST_ARITH     = 3'd3,
    ST_BORROW    = 3'd4,
    ST_BUDGET    = 3'd5,
    ST_FAILED    = 3'd6,
    ST_HALTED    = 3'd7
  } status_t;

  typedef struct packed {
    logic              fail;
    logic [WORD_W-1:0] value;
  } alu_res_t;

  typedef struct packed {
    logic              done;
    logic              ovf;
    logic [WORD_W-1:0] prod;
  } mul_res_t;

endpackage

/* hdl/csm_if.sv */
interface csm_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  mode;
  logic [63:0] push_value;

  modport source (output valid, output mode, output push_value, input ready);
  modport sink   (input valid, input mode, input push_value, output ready);
endinterface

interface csm_out_if #(
  parameter int DEPTH_W = 5
);
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic [63:0]        popped_value;
  logic               popped_valid;
  logic [63:0]        top_value;
  logic [DEPTH_W-1:0] word_count;

  modport source (output valid, output status, output popped_value, output popped_valid,
                  output top_value, output word_count, input ready);
  modport sink   (input valid, input status, input popped_value, input popped_valid,
                  input top_value, input word_count, output ready);
endinterface

/* hdl/checked_stack_machine_execute_core.sv */
// checked stack machine execute core: runs one decoded instruction per request on a stack
// of NUM_WORDS 64-bit words held in a single-port-read RAM, with the top of stack cached
// in a register. a start request opens a run; add, sub and mul fail instead of wrapping,
// stack bounds and the instruction budget (cfg register, reset 4096) are checked, and a
// failing instruction leaves the stack untouched and poisons the run until the next start.
// every request returns exactly one result. the block takes one request at a time:
// start, push, dup, halt, unused codes and every early failure go from check to done;
// two-operand logic/add/sub, drop and pop with two or more words add an exec state, swap
// also a second write state, and mul waits on the 4-step 32x32 shared multiplier.
// a result waits in an output register, so the next request is accepted while it is held.
// the stack RAM needs no clearing pass: only entries written in the current run are read.
module checked_stack_machine_execute_core #(
  parameter int NUM_WORDS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  csm_in_if.sink                              in_chan,
  csm_out_if.source                           out_chan,
  input  logic                                cfg_wr_en,
  input  logic [csm_pkg::BUDGET_W-1:0]        cfg_wr_data
);
  import csm_pkg::*;

  localparam int DEPTH_W = $clog2(NUM_WORDS + 1);
  localparam int AW      = $clog2(NUM_WORDS);
  localparam logic [DEPTH_W-1:0] DEPTH_LIM = DEPTH_W'(NUM_WORDS);
  localparam logic [DEPTH_W-1:0] ONE       = DEPTH_W'(1);
  localparam logic [DEPTH_W-1:0] TWO       = DEPTH_W'(2);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CHECK = 7'b0000010,
    S_EXEC  = 7'b0000100,
    S_MUL   = 7'b0001000,
    S_SWAP  = 7'b0010000,
    S_DONE  = 7'b0100000,
    S_SPARE = 7'b1000000
  } state_t;

  // sequencer and run state
  state_t                state_r, state_nxt;
  logic [DEPTH_W-1:0]    depth_r, depth_nxt;
  logic [BUDGET_W-1:0]   count_r, count_nxt;
  logic                  failed_r, failed_nxt;
  logic                  finished_r, finished_nxt;
  logic [BUDGET_W-1:0]   budget_r;

  // request and working payload
  logic [MODE_W-1:0]     mode_r, mode_nxt;
  logic [WORD_W-1:0]     push_r, push_nxt;
  logic [WORD_W-1:0]     tos_r, tos_nxt;
  status_t               status_r, status_nxt;
  logic [WORD_W-1:0]     pop_r, pop_nxt;
  logic                  popv_r, popv_nxt;

  // output register
  logic                  out_valid_r;
  logic                  out_load;
  status_t               out_status_r;
  logic [WORD_W-1:0]     out_pop_r;
  logic                  out_popv_r;
  logic [WORD_W-1:0]     out_top_r;
  logic [DEPTH_W-1:0]    out_depth_r;

  // stack RAM port and shared units
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [WORD_W-1:0]     wr_data;
  logic                  rd_en;
  logic [WORD_W-1:0]     rd_data;
  logic                  mul_start;
  alu_res_t              alu_res;
  mul_res_t              mul_res;
  logic [DEPTH_W-1:0]    dm1;
  logic [DEPTH_W-1:0]    dm2;
  logic [AW-1:0]         addr_top;
  logic [AW-1:0]         addr_next;
  logic [AW-1:0]         addr_free;

  assign dm1       = depth_r - ONE;
  assign dm2       = depth_r - TWO;
  assign addr_top  = dm1[AW-1:0];
  assign addr_next = dm2[AW-1:0];
  assign addr_free = depth_r[AW-1:0];

  csm_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NUM_WORDS)
  ) u_stack (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (addr_next),
    .rd_data (rd_data)
  );

  // second operand is always the cached top, first comes from the RAM read
  csm_alu u_alu (
    .op  (mode_r),
    .a   (rd_data),
    .b   (tos_r),
    .res (alu_res)
  );

  csm_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (rd_data),
    .b     (tos_r),
    .res   (mul_res)
  );

  assign in_chan.ready = (state_r == S_IDLE);
  assign out_load      = (state_r == S_DONE) && (!out_valid_r || out_chan.ready);

  always_comb begin
    state_nxt    = state_r;
    depth_nxt    = depth_r;
    count_nxt    = count_r;
    failed_nxt   = failed_r;
    finished_nxt = finished_r;
    mode_nxt     = mode_r;
    push_nxt     = push_r;
    tos_nxt      = tos_r;
    status_nxt   = status_r;
    pop_nxt      = pop_r;
    popv_nxt     = popv_r;
    wr_en        = 1'b0;
    wr_addr      = addr_top;
    wr_data      = tos_r;
    rd_en        = 1'b0;
    mul_start    = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          mode_nxt   = in_chan.mode;
          push_nxt   = in_chan.push_value;
          status_nxt = ST_OK;
          pop_nxt    = '0;
          popv_nxt   = 1'b0;
          state_nxt  = S_CHECK;
        end
      end

      // priority: start, sticky flags, unused codes, budget, stack bounds
      S_CHECK: begin
        state_nxt = S_DONE;
        if (mode_r == MODE_START) begin
          depth_nxt    = '0;
          count_nxt    = '0;
          failed_nxt   = 1'b0;
          finished_nxt = 1'b0;
        end else if (failed_r) begin
          status_nxt = ST_FAILED;
        end else if (finished_r) begin
          status_nxt = ST_HALTED;
        end else if (mode_r > MODE_HALT) begin
          status_nxt = ST_OK;
        end else if (count_r >= budget_r) begin
          status_nxt = ST_BUDGET;
          failed_nxt = 1'b1;
        end else begin
          case (mode_r)
            MODE_PUSH: begin
              if (depth_r >= DEPTH_LIM) begin
                status_nxt = ST_OVERFLOW;
                failed_nxt = 1'b1;
              end else begin
                wr_en     = 1'b1;
                wr_addr   = addr_free;
                wr_data   = push_r;
                tos_nxt   = push_r;
                depth_nxt = depth_r + ONE;
                count_nxt = count_r + 1'b1;
              end
            end
            MODE_ADD, MODE_SUB, MODE_MUL, MODE_AND, MODE_OR, MODE_XOR, MODE_EQ,
            MODE_SWAP: begin
              if (depth_r < TWO) begin
                status_nxt = ST_UNDERFLOW;
                failed_nxt = 1'b1;
              end else begin
                rd_en     = 1'b1;
                state_nxt = S_EXEC;
              end
            end
            MODE_DUP: begin
              if (depth_r == '0) begin
                status_nxt = ST_UNDERFLOW;
                failed_nxt = 1'b1;
              end else if (depth_r >= DEPTH_LIM) begin
                status_nxt = ST_OVERFLOW;
                failed_nxt = 1'b1;
              end else begin
                wr_en     = 1'b1;
                wr_addr   = addr_free;
                wr_data   = tos_r;
                depth_nxt = depth_r + ONE;
                count_nxt = count_r + 1'b1;
              end
            end
            MODE_DROP, MODE_POP: begin
              if (depth_r == '0) begin
                status_nxt = ST_UNDERFLOW;
                failed_nxt = 1'b1;
              end else begin
                depth_nxt = dm1;
                count_nxt = count_r + 1'b1;
                if (mode_r == MODE_POP) begin
                  pop_nxt  = tos_r;
                  popv_nxt = 1'b1;
                end
                // new top must be fetched from the word below
                if (depth_r >= TWO) begin
                  rd_en     = 1'b1;
                  state_nxt = S_EXEC;
                end
              end
            end
            MODE_HALT: begin
              count_nxt    = count_r + 1'b1;
              finished_nxt = 1'b1;
              status_nxt   = ST_HALTED;
            end
            default: ;
          endcase
        end
      end

      // RAM word below the top is now in rd_data
      S_EXEC: begin
        state_nxt = S_DONE;
        case (mode_r)
          MODE_MUL: begin
            mul_start = 1'b1;
            state_nxt = S_MUL;
          end
          MODE_SWAP: begin
            wr_en     = 1'b1;
            wr_addr   = addr_next;
            wr_data   = tos_r;
            state_nxt = S_SWAP;
          end
          MODE_DROP, MODE_POP: begin
            tos_nxt = rd_data;
          end
          default: begin
            if (alu_res.fail) begin
              status_nxt = (mode_r == MODE_SUB) ? ST_BORROW : ST_ARITH;
              failed_nxt = 1'b1;
            end else begin
              wr_en     = 1'b1;
              wr_addr   = addr_next;
              wr_data   = alu_res.value;
              tos_nxt   = alu_res.value;
              depth_nxt = dm1;
              count_nxt = count_r + 1'b1;
            end
          end
        endcase
      end

      S_MUL: begin
        if (mul_res.done) begin
          state_nxt = S_DONE;
          if (mul_res.ovf) begin
            status_nxt = ST_ARITH;
            failed_nxt = 1'b1;
          end else begin
            wr_en     = 1'b1;
            wr_addr   = addr_next;
            wr_data   = mul_res.prod;
            tos_nxt   = mul_res.prod;
            depth_nxt = dm1;
            count_nxt = count_r + 1'b1;
          end
        end
      end

      // old second word goes on top
      S_SWAP: begin
        wr_en     = 1'b1;
        wr_addr   = addr_top;
        wr_data   = rd_data;
        tos_nxt   = rd_data;
        count_nxt = count_r + 1'b1;
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      depth_r     <= '0;
      count_r     <= '0;
      failed_r    <= 1'b0;
      finished_r  <= 1'b0;
      budget_r    <= BUDGET_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      depth_r    <= depth_nxt;
      count_r    <= count_nxt;
      failed_r   <= failed_nxt;
      finished_r <= finished_nxt;
      if (cfg_wr_en) begin
        budget_r <= cfg_wr_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    mode_r   <= mode_nxt;
    push_r   <= push_nxt;
    tos_r    <= tos_nxt;
    status_r <= status_nxt;
    pop_r    <= pop_nxt;
    popv_r   <= popv_nxt;
    if (out_load) begin
      out_status_r <= status_r;
      out_pop_r    <= pop_r;
      out_popv_r   <= popv_r;
      out_top_r    <= (depth_r == '0) ? '0 : tos_r;
      out_depth_r  <= depth_r;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.status       = out_status_r;
  assign out_chan.popped_value = out_pop_r;
  assign out_chan.popped_valid = out_popv_r;
  assign out_chan.top_value    = out_top_r;
  assign out_chan.word_count   = out_depth_r;

  // stack never holds more words than it has room for
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DEPTH_LIM)
    else $error("stack depth beyond capacity");

  // a run cannot be both failed and halted
  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(failed_r && finished_r))
    else $error("run both failed and halted");

  // multiplier reports only while the sequencer waits for it
  a_mul_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    mul_res.done |-> (state_r == S_MUL))
    else $error("multiplier done outside mul wait");

  // a popped word only comes with a clean status
  a_pop_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.popped_valid) |-> (out_chan.status == ST_OK))
    else $error("popped word with error status");

  // an accepted request is checked in the next cycle
  a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> (state_r == S_CHECK))
    else $error("accepted request not checked");

endmodule

/* hdl/csm_ram.sv */
module csm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

/* hdl/csm_alu.sv */
module csm_alu (
  input  logic [3:0]             op,
  input  logic [63:0]            a,
  input  logic [63:0]            b,
  output csm_pkg::alu_res_t      res
);
  import csm_pkg::*;

  logic        is_sub;
  logic [64:0] sum;

  // one 65-bit adder serves add and subtract
  assign is_sub = (op == MODE_SUB);
  assign sum    = {1'b0, a} + {1'b0, is_sub ? ~b : b} + {{WORD_W{1'b0}}, is_sub};

  always_comb begin
    res = '0;
    unique case (op)
      MODE_ADD: begin
        res.value = sum[WORD_W-1:0];
        res.fail  = sum[WORD_W];
      end
      MODE_SUB: begin
        res.value = sum[WORD_W-1:0];
        res.fail  = ~sum[WORD_W];
      end
      MODE_AND: res.value = a & b;
      MODE_OR:  res.value = a | b;
      MODE_XOR: res.value = a ^ b;
      MODE_EQ:  res.value = {{(WORD_W-1){1'b0}}, (a == b)};
      default:  res = '0;
    endcase
  end

endmodule

/* hdl/csm_mul.sv */
module csm_mul (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [63:0]       a,
  input  logic [63:0]       b,
  output csm_pkg::mul_res_t res
);
  import csm_pkg::*;

  logic        busy_r;
  logic [1:0]  phase_r;
  logic        done_r;
  logic [63:0] a_r;
  logic [63:0] b_r;
  logic [63:0] prod_r;
  logic [63:0] lo_r;
  logic [31:0] mid_r;
  logic        ovf_r;
  logic [63:0] res_r;
  logic [31:0] m_a;
  logic [31:0] m_b;
  logic [32:0] mid_sum;
  logic [32:0] hi_sum;

  // phase 0 lo*lo, phase 1 hi(a)*lo(b), phase 2 lo(a)*hi(b)
  assign m_a     = (phase_r == 2'd1) ? a_r[63:32] : a_r[31:0];
  assign m_b     = (phase_r == 2'd2) ? b_r[63:32] : b_r[31:0];
  assign mid_sum = {1'b0, mid_r} + {1'b0, prod_r[31:0]};
  assign hi_sum  = {1'b0, lo_r[63:32]} + {1'b0, mid_sum[31:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      phase_r <= 2'd0;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r  <= 1'b1;
        phase_r <= 2'd0;
      end else if (busy_r) begin
        phase_r <= phase_r + 2'd1;
        if (phase_r == 2'd3) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      ovf_r <= (|a[63:32]) && (|b[63:32]);
    end else if (busy_r) begin
      prod_r <= m_a * m_b;
      case (phase_r)
        2'd1: lo_r <= prod_r;
        2'd2: begin
          mid_r <= prod_r[31:0];
          ovf_r <= ovf_r | (|prod_r[63:32]);
        end
        2'd3: begin
          res_r <= {hi_sum[31:0], lo_r[31:0]};
          ovf_r <= ovf_r | (|prod_r[63:32]) | mid_sum[32] | hi_sum[32];
        end
        default: ;
      endcase
    end
  end

  assign res.done = done_r;
  assign res.ovf  = ovf_r;
  assign res.prod = res_r;

endmodule

/* tb/sv/tb_checked_stack_machine_execute_core.sv */
module tb_checked_stack_machine_execute_core;
  timeunit 1ns;
  timeprecision 1ps;
  import csm_pkg::*;

  localparam int STACK_WORDS  = 16;
  localparam int CYCLE_LIMIT  = 1_000_000;
  // longest accept-to-ready path is mul, plus the output register
  localparam int SETTLE_CYCLES = 16;
  localparam int LONG_HOLD     = 400;

  // codes the block treats as no-ops
  localparam logic [MODE_W-1:0] MODE_SPARE_A = 4'd14;
  localparam logic [MODE_W-1:0] MODE_SPARE_B = 4'd15;

  localparam logic [WORD_W-1:0] ALL_ONES = {WORD_W{1'b1}};
  localparam logic [WORD_W-1:0] BIT32    = 64'h0000_0001_0000_0000;

  typedef struct packed {
    status_t           status;
    logic [WORD_W-1:0] popped_value;
    logic              popped_valid;
    logic [WORD_W-1:0] top_value;
    logic [4:0]        word_count;
  } stack_result_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [WORD_W-1:0] operand;
    logic              pinned;   // expected result typed in below
    stack_result_t     want;
  } directed_row_t;

  // directed requests: extremes, every operation and the special cases
  localparam int NUM_DIRECTED = 33;
  localparam directed_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    // no start yet: reset leaves a run open
    '{MODE_PUSH,   ALL_ONES,   1'b1, '{ST_OK,        64'd0, 1'b0, ALL_ONES, 5'd1}},
    '{MODE_PUSH,   64'd1,      1'b1, '{ST_OK,        64'd0, 1'b0, 64'd1,    5'd2}},
    // carry out of add fails and leaves the stack alone
    '{MODE_ADD,    64'd0,      1'b1, '{ST_ARITH,     64'd0, 1'b0, 64'd1,    5'd2}},
    // poisoned run: everything but start reports failed, spare codes too
    '{MODE_PUSH,   64'd0,      1'b1, '{ST_FAILED,    64'd0, 1'b0, 64'd1,    5'd2}},
    '{MODE_SPARE_A, ALL_ONES,  1'b1, '{ST_FAILED,    64'd0, 1'b0, 64'd1,    5'd2}},
    '{MODE_START,  ALL_ONES,   1'b1, '{ST_OK,        64'd0, 1'b0, 64'd0,    5'd0}},
    // spare code in an open run does nothing
    '{MODE_SPARE_B, 64'd5,     1'b1, '{ST_OK,        64'd0, 1'b0, 64'd0,    5'd0}},
    '{MODE_POP,    64'd0,      1'b1, '{ST_UNDERFLOW, 64'd0, 1'b0, 64'd0,    5'd0}},
    '{MODE_START,  64'd0,      1'b1, '{ST_OK,        64'd0, 1'b0, 64'd0,    5'd0}},
    '{MODE_PUSH,   64'd0,      1'b1, '{ST_OK,        64'd0, 1'b0, 64'd0,    5'd1}},
    '{MODE_PUSH,   64'd1,      1'b1, '{ST_OK,        64'd0, 1'b0, 64'd1,    5'd2}},
    // 0 - 1 borrows
    '{MODE_SUB,    64'd0,      1'b1, '{ST_BORROW,    64'd0, 1'b0, 64'd1,    5'd2}},
    '{MODE_START,  64'd0,      1'b1, '{ST_OK,        64'd0, 1'b0, 64'd0,    5'd0}},
    '{MODE_PUSH,   BIT32,      1'b0, '0},
    '{MODE_DUP,    64'd0,      1'b0, '0},
    // 2^32 * 2^32 is one bit past the word
    '{MODE_MUL,    64'd0,      1'b1, '{ST_ARITH,     64'd0, 1'b0, BIT32,    5'd2}},
    '{MODE_START,  64'd0,      1'b1, '{ST_OK,        64'd0, 1'b0, 64'd0,    5'd0}},
    '{MODE_PUSH,   {16{4'hA}}, 1'b0, '0},
    '{MODE_PUSH,   {16{4'h5}}, 1'b0, '0},
    '{MODE_SWAP,   64'd0,      1'b0, '0},
    '{MODE_XOR,    64'd0,      1'b0, '0},
    '{MODE_PUSH,   {8{8'h0F}}, 1'b0, '0},
    '{MODE_AND,    64'd0,      1'b0, '0},
    '{MODE_PUSH,   {8{8'hF0}}, 1'b0, '0},
    '{MODE_OR,     64'd0,      1'b0, '0},
    '{MODE_DUP,    64'd0,      1'b0, '0},
    '{MODE_EQ,     64'd0,      1'b1, '{ST_OK,        64'd0, 1'b0, 64'd1,    5'd1}},
    '{MODE_POP,    64'd0,      1'b1, '{ST_OK,        64'd1, 1'b1, 64'd0,    5'd0}},
    '{MODE_PUSH,   ALL_ONES,   1'b0, '0},
    '{MODE_DROP,   64'd0,      1'b1, '{ST_OK,        64'd0, 1'b0, 64'd0,    5'd0}},
    '{MODE_HALT,   64'd0,      1'b1, '{ST_HALTED,    64'd0, 1'b0, 64'd0,    5'd0}},
    // after halt nothing runs until the next start
    '{MODE_PUSH,   64'd7,      1'b1, '{ST_HALTED,    64'd0, 1'b0, 64'd0,    5'd0}},
    '{MODE_START,  64'd0,      1'b1, '{ST_OK,        64'd0, 1'b0, 64'd0,    5'd0}}
  };

  logic                clk;
  logic                rst_n;
  logic                cfg_wr_en;
  logic [BUDGET_W-1:0] cfg_wr_data;

  csm_in_if                    in_if ();
  csm_out_if #(.DEPTH_W(5))    out_if ();

  checked_stack_machine_execute_core #(
    .NUM_WORDS(STACK_WORDS)
  ) u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_if),
    .out_chan    (out_if),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // mirror of the block state, advanced on each accepted request
  logic [WORD_W-1:0] words_mirror [STACK_WORDS];
  int                depth_mirror;
  int unsigned       steps_taken;
  int unsigned       step_limit;
  bit                run_poisoned;
  bit                run_stopped;

  stack_result_t pending_results [$];
  int            mismatches;
  int            cycle_count;

  // idle knobs, percent chance per request / per cycle
  int in_gap_pct;
  int out_stall_pct;
  int hold_left;
  int run_push_pct;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int idle_length();
    // mostly short, now and then a long one
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
  endfunction

  function automatic logic [WORD_W-1:0] random_word();
    case ($urandom_range(0, 5))
      0:       return {60'd0, 4'($urandom)};
      1:       return ~{60'd0, 4'($urandom)};
      2:       return {$urandom, $urandom};
      3:       return {32'd0, $urandom};
      4:       return 64'd1 << $urandom_range(0, 63);
      default: return {48'd0, 16'($urandom)};
    endcase
  endfunction

  function automatic void clear_run();
    foreach (words_mirror[i]) words_mirror[i] = '0;
    depth_mirror = 0;
    steps_taken  = 0;
    run_poisoned = 1'b0;
    run_stopped  = 1'b0;
  endfunction

  // predicts one result and advances the mirror
  function automatic stack_result_t execute_instruction(input logic [MODE_W-1:0] m,
                                                        input logic [WORD_W-1:0] v);
    stack_result_t r;
    status_t       st;
    logic [WORD_W-1:0] a, b;
    logic [WORD_W:0]   sum;
    logic [2*WORD_W-1:0] prod;
    r  = '0;
    st = ST_OK;
    a  = '0;
    b  = '0;
    if (m == MODE_START) begin
      clear_run();
    end else if (run_poisoned) begin
      st = ST_FAILED;
    end else if (run_stopped) begin
      st = ST_HALTED;
    end else if (m > MODE_HALT) begin
      st = ST_OK;
    end else if (steps_taken >= step_limit) begin
      // budget goes before any stack check
      st = ST_BUDGET;
      run_poisoned = 1'b1;
    end else begin
      if (depth_mirror >= 1) b = words_mirror[depth_mirror-1];
      if (depth_mirror >= 2) a = words_mirror[depth_mirror-2];
      case (m)
        MODE_PUSH: begin
          if (depth_mirror >= STACK_WORDS) st = ST_OVERFLOW;
          else begin
            words_mirror[depth_mirror] = v;
            depth_mirror++;
          end
        end
        MODE_ADD, MODE_SUB, MODE_MUL, MODE_AND, MODE_OR, MODE_XOR, MODE_EQ: begin
          if (depth_mirror < 2) st = ST_UNDERFLOW;
          else begin
            sum  = {1'b0, a} + {1'b0, b};
            prod = {64'd0, a} * {64'd0, b};
            case (m)
              MODE_ADD: begin
                if (sum[WORD_W]) st = ST_ARITH;
                else a = sum[WORD_W-1:0];
              end
              MODE_SUB: begin
                if (a < b) st = ST_BORROW;
                else a = a - b;
              end
              MODE_MUL: begin
                if (prod[2*WORD_W-1:WORD_W] != '0) st = ST_ARITH;
                else a = prod[WORD_W-1:0];
              end
              MODE_AND: a = a & b;
              MODE_OR:  a = a | b;
              MODE_XOR: a = a ^ b;
              default:  a = (a == b) ? 64'd1 : 64'd0;
            endcase
            if (st == ST_OK) begin
              words_mirror[depth_mirror-2] = a;
              depth_mirror--;
            end
          end
        end
        MODE_DUP: begin
          if (depth_mirror == 0) st = ST_UNDERFLOW;
          else if (depth_mirror >= STACK_WORDS) st = ST_OVERFLOW;
          else begin
            words_mirror[depth_mirror] = b;
            depth_mirror++;
          end
        end
        MODE_DROP: begin
          if (depth_mirror == 0) st = ST_UNDERFLOW;
          else depth_mirror--;
        end
        MODE_SWAP: begin
          if (depth_mirror < 2) st = ST_UNDERFLOW;
          else begin
            words_mirror[depth_mirror-1] = a;
            words_mirror[depth_mirror-2] = b;
          end
        end
        MODE_POP: begin
          if (depth_mirror == 0) st = ST_UNDERFLOW;
          else begin
            r.popped_value = b;
            r.popped_valid = 1'b1;
            depth_mirror--;
          end
        end
        default: begin
          st = ST_HALTED;
          run_stopped = 1'b1;
        end
      endcase
      // halt counts against the budget, failures poison the run
      if (st == ST_OK || st == ST_HALTED) steps_taken++;
      else run_poisoned = 1'b1;
    end
    r.status     = st;
    r.word_count = 5'(depth_mirror);
    r.top_value  = (depth_mirror > 0) ? words_mirror[depth_mirror-1] : '0;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string field, input logic [WORD_W-1:0] got,
                             input logic [WORD_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %h want %h", field, got, want));
  endtask

  // one request; the expectation is queued at the accepting edge
  task automatic drive_request(input logic [MODE_W-1:0] m, input logic [WORD_W-1:0] v,
                               input bit pinned = 1'b0, input stack_result_t pinned_result = '0);
    stack_result_t predicted;
    int            gap;
    gap = ($urandom_range(0, 99) < in_gap_pct) ? idle_length() : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_if.valid      <= 1'b0;
      in_if.mode       <= 4'($urandom);
      in_if.push_value <= {$urandom, $urandom};
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_if.valid      <= 1'b1;
    in_if.mode       <= m;
    in_if.push_value <= v;
    do @(posedge clk); while (!in_if.ready);
    // the mirror always advances, a typed row only overrides what is expected
    predicted = execute_instruction(m, v);
    pending_results.push_back(pinned ? pinned_result : predicted);
  endtask

  // drop valid and wait for every queued result to come back
  task automatic drain_results();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_budget(input logic [BUDGET_W-1:0] limit);
    drain_results();
    // every request yields a result, still let the pipe settle
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= limit;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= 16'($urandom);
    step_limit = limit;
  endtask

  // mostly well-formed programs with random words, plus restarts and noise
  task automatic issue_random_requests(input int count);
    int                pick;
    logic [MODE_W-1:0] m;
    logic [WORD_W-1:0] v;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      v    = random_word();
      if (run_poisoned || run_stopped) begin
        // usually restart, sometimes poke the dead run
        m = (pick < 75) ? MODE_START : 4'($urandom_range(0, 15));
      end else if (pick < 2) begin
        m = MODE_START;
      end else if (pick < 4) begin
        m = $urandom_range(0, 1) ? MODE_SPARE_A : MODE_SPARE_B;
      end else if (pick < 6) begin
        m = MODE_HALT;
      end else if (pick < 9) begin
        m = 4'($urandom_range(0, 15));
      end else if (depth_mirror < 2 || $urandom_range(0, 99) < run_push_pct) begin
        // growth; at a full stack this overflows
        m = (depth_mirror > 0 && $urandom_range(0, 4) == 0) ? MODE_DUP : MODE_PUSH;
      end else begin
        m = 4'($urandom_range(MODE_ADD, MODE_POP));
      end
      // each run gets its own push bias so some climb to a full stack
      if (m == MODE_START) run_push_pct = $urandom_range(30, 75);
      drive_request(m, v);
    end
  endtask

  // result side: random back-pressure, plus a long hold on request
  initial begin
    int stall_left;
    stall_left   = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else begin
        out_if.ready <= 1'b1;
        if ($urandom_range(0, 99) < out_stall_pct) stall_left = idle_length();
      end
    end
  end

  // result checker
  initial begin
    stack_result_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result with nothing pending, status %0d", out_if.status));
        end else begin
          want = pending_results.pop_front();
          check_field("status", out_if.status, want.status);
          check_field("popped_value", out_if.popped_value, want.popped_value);
          check_field("popped_valid", out_if.popped_valid, want.popped_valid);
          check_field("top_value", out_if.top_value, want.top_value);
          check_field("word_count", out_if.word_count, want.word_count);
        end
      end
    end
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    // everything known from time zero
    rst_n            = 1'b0;
    cfg_wr_en        = 1'b0;
    cfg_wr_data      = '0;
    in_if.valid      = 1'b0;
    in_if.mode       = '0;
    in_if.push_value = '0;
    mismatches       = 0;
    hold_left        = 0;
    run_push_pct     = 50;
    in_gap_pct       = 30;
    out_stall_pct    = 30;
    clear_run();
    step_limit = BUDGET_RESET;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table at the reset budget
    foreach (DIRECTED_ROWS[i])
      drive_request(DIRECTED_ROWS[i].mode, DIRECTED_ROWS[i].operand,
                    DIRECTED_ROWS[i].pinned, DIRECTED_ROWS[i].want);

    // widest budget: a stretch with no idling, then random idling
    set_budget(16'hFFFF);
    in_gap_pct    = 0;
    out_stall_pct = 0;
    issue_random_requests(150);
    in_gap_pct    = 25;
    out_stall_pct = 25;
    issue_random_requests(350);

    // budget of one: second instruction of every run runs out
    set_budget(16'd1);
    issue_random_requests(80);

    // short budgets, with a long result hold and a full drain
    set_budget(16'($urandom_range(5, 40)));
    issue_random_requests(200);
    in_gap_pct = 5;
    hold_left  = LONG_HOLD;
    issue_random_requests(100);
    drain_results();
    in_gap_pct = 25;
    issue_random_requests(200);

    // mid budgets under heavier back-pressure
    set_budget(16'($urandom_range(41, 400)));
    out_stall_pct = 60;
    issue_random_requests(650);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
